FILE: design/pos_pkg.sv
`timescale 1ns / 1ps

package pos_pkg;

  localparam int CNT_W = 16;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_WARMUP     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd2;

  localparam logic [CNT_W-1:0] WARMUP_RST     = 16'd1000;
  localparam logic [CNT_W-1:0] PULSE_RST      = 16'd200;
  localparam logic [CNT_W-1:0] LONG_PRESS_RST = 16'd5000;

  localparam logic [7:0] CMD_ON       = 8'h00;
  localparam logic [7:0] CMD_SLEEP    = 8'h20;
  localparam logic [7:0] CMD_SHUTDOWN = 8'hFF;

  localparam logic [2:0] SYS_OFF          = 3'd0;
  localparam logic [2:0] SYS_BOOTING      = 3'd1;
  localparam logic [2:0] SYS_BOARD_ON     = 3'd2;
  localparam logic [2:0] SYS_ON           = 3'd3;
  localparam logic [2:0] SYS_SLEEPING     = 3'd4;
  localparam logic [2:0] SYS_SHUTTING_DN  = 3'd5;

  localparam logic [1:0] LED_DARK  = 2'd0;
  localparam logic [1:0] LED_FULL  = 2'd1;
  localparam logic [1:0] LED_PULSE = 2'd2;

  typedef enum logic [6:0] {
    ST_OFF         = 7'b0000001,
    ST_BOOTING     = 7'b0000010,
    ST_BOARD_ON    = 7'b0000100,
    ST_ON          = 7'b0001000,
    ST_SLEEPING    = 7'b0010000,
    ST_SHUTTING_DN = 7'b0100000,
    ST_BOARD_OFF   = 7'b1000000
  } mode_t;

  typedef struct packed {
    logic       tick_elapsed;
    logic       button_pressed;
    logic       rail_powered;
    logic       wake_event;
    logic       command_valid;
    logic [7:0] command_byte;
  } item_t;

  typedef struct packed {
    logic       atx_enable;
    logic       board_button;
    logic [2:0] system_state;
    logic [1:0] led_mode;
  } result_t;

  typedef struct packed {
    logic [CNT_W-1:0] warmup_ticks;
    logic [CNT_W-1:0] pulse_ticks;
    logic [CNT_W-1:0] long_press_ticks;
  } cfg_t;

  typedef struct packed {
    mode_t            mode;
    logic             press_handled;
    logic             last_pressed;
    logic [CNT_W-1:0] press_elapsed;
    logic             warmup_active;
    logic [CNT_W-1:0] warmup_elapsed;
    logic             pulse_active;
    logic [CNT_W-1:0] pulse_elapsed;
    logic             atx;
    logic             button_drive;
  } seq_state_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
  endfunction

  function automatic logic is_board_state(input mode_t m);
    return (m == ST_BOARD_ON) || (m == ST_ON) || (m == ST_SLEEPING) ||
           (m == ST_SHUTTING_DN);
  endfunction

endpackage

FILE: design/pos_cfg.sv
`timescale 1ns / 1ps

module pos_cfg
  import pos_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [CNT_W-1:0]     wr_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.warmup_ticks     <= WARMUP_RST;
      cfg_r.pulse_ticks      <= PULSE_RST;
      cfg_r.long_press_ticks <= LONG_PRESS_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_WARMUP:     cfg_r.warmup_ticks     <= wr_data;
        CFG_PULSE:      cfg_r.pulse_ticks      <= wr_data;
        CFG_LONG_PRESS: cfg_r.long_press_ticks <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: design/pos_step.sv
`timescale 1ns / 1ps

module pos_step
  import pos_pkg::*;
(
  input  seq_state_t st,
  input  item_t      item,
  input  cfg_t       cfg,
  output seq_state_t st_nxt,
  output result_t    res
);

  always_comb begin
    seq_state_t s;
    logic       passthrough;
    logic [1:0] led;
    logic [2:0] code;

    s = st;

    // timers advance on the tick
    if (item.tick_elapsed) begin
      if (s.warmup_active) s.warmup_elapsed = sat_inc(s.warmup_elapsed);
      if (s.pulse_active)  s.pulse_elapsed  = sat_inc(s.pulse_elapsed);
      if (s.last_pressed)  s.press_elapsed  = sat_inc(s.press_elapsed);
    end

    // wake
    if (item.wake_event && s.mode == ST_OFF) begin
      s.atx            = 1'b1;
      s.warmup_active  = 1'b1;
      s.warmup_elapsed = '0;
      s.mode           = ST_BOOTING;
    end

    // pulse end
    if (s.pulse_active && s.pulse_elapsed >= cfg.pulse_ticks) begin
      s.button_drive = 1'b0;
      s.pulse_active = 1'b0;
    end

    // warmup end
    if (s.warmup_active && s.warmup_elapsed >= cfg.warmup_ticks) begin
      s.pulse_active  = 1'b1;
      s.pulse_elapsed = '0;
      s.button_drive  = 1'b1;
      s.warmup_active = 1'b0;
    end

    // rail tracking
    if (!item.rail_powered && is_board_state(s.mode)) s.mode = ST_BOARD_OFF;
    if (item.rail_powered && s.mode == ST_BOOTING)    s.mode = ST_BOARD_ON;

    // button
    if (item.button_pressed != s.last_pressed) begin
      if (item.button_pressed) s.press_elapsed = '0;
      s.press_handled = 1'b0;
    end
    s.last_pressed = item.button_pressed;
    passthrough = !((s.mode == ST_OFF) || (s.mode == ST_BOOTING) ||
                    (s.mode == ST_BOARD_OFF));
    if (item.button_pressed && s.press_elapsed >= cfg.long_press_ticks) begin
      s.press_handled = 1'b1;
      s.button_drive  = 1'b0;
      s.pulse_active  = 1'b0;
      s.warmup_active = 1'b0;
      s.atx           = 1'b0;
      s.mode          = ST_OFF;
    end else if (!s.press_handled) begin
      if (!passthrough) begin
        if (s.mode == ST_OFF && item.button_pressed) begin
          s.atx            = 1'b1;
          s.warmup_active  = 1'b1;
          s.warmup_elapsed = '0;
          s.mode           = ST_BOOTING;
          s.press_handled  = 1'b1;
        end
      end else if (!s.pulse_active) begin
        s.button_drive = item.button_pressed;
      end
    end

    // serial command
    if (item.command_valid && is_board_state(s.mode)) begin
      unique case (item.command_byte)
        CMD_ON:       s.mode = ST_ON;
        CMD_SHUTDOWN: s.mode = ST_SHUTTING_DN;
        CMD_SLEEP:    s.mode = ST_SLEEPING;
        default: ;
      endcase
    end

    // led mode
    priority if (s.mode == ST_OFF) led = LED_DARK;
    else if (s.mode == ST_ON)      led = LED_FULL;
    else                           led = LED_PULSE;

    // final power-down
    if (s.mode == ST_BOARD_OFF) begin
      s.atx  = 1'b0;
      s.mode = ST_OFF;
    end

    unique case (s.mode)
      ST_OFF:         code = SYS_OFF;
      ST_BOOTING:     code = SYS_BOOTING;
      ST_BOARD_ON:    code = SYS_BOARD_ON;
      ST_ON:          code = SYS_ON;
      ST_SLEEPING:    code = SYS_SLEEPING;
      ST_SHUTTING_DN: code = SYS_SHUTTING_DN;
      default:        code = SYS_OFF;
    endcase

    st_nxt           = s;
    res.atx_enable   = s.atx;
    res.board_button = s.button_drive;
    res.system_state = code;
    res.led_mode     = led;
  end

endmodule

FILE: design/power_on_sequencer.sv
`timescale 1ns / 1ps

// Power-on sequencer: each request carries the millisecond tick, button and rail levels, a wake
// event and an optional serial command, and yields exactly one result with the ATX enable, the
// board button drive, the system state and the LED mode. A request is taken into an input
// register, the whole sequencing step runs as combinational logic against the state registers,
// and the result lands in an output register, so one request is taken every clock while the
// output register is free or out_ready is high; a stalled output holds the input register.
// Configuration registers (warmup, pulse and long-press tick counts) are written through the
// cfg port, which is always ready.

module power_on_sequencer
  import pos_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  item_t                in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output result_t              out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0]     cfg_data
);

  item_t      in_data_r;
  logic       in_vld_r;
  result_t    out_data_r;
  logic       out_vld_r;
  seq_state_t st_r;
  seq_state_t st_nxt;
  result_t    res;
  cfg_t       cfg;
  logic       step_go;

  assign cfg_ready = 1'b1;

  pos_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  pos_step u_step (
    .st     (st_r),
    .item   (in_data_r),
    .cfg    (cfg),
    .st_nxt (st_nxt),
    .res    (res)
  );

  assign step_go  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || step_go;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_vld_r <= 1'b1;
    end else if (step_go) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode           <= ST_OFF;
      st_r.press_handled  <= 1'b0;
      st_r.last_pressed   <= 1'b0;
      st_r.press_elapsed  <= '0;
      st_r.warmup_active  <= 1'b0;
      st_r.warmup_elapsed <= '0;
      st_r.pulse_active   <= 1'b0;
      st_r.pulse_elapsed  <= '0;
      st_r.atx            <= 1'b0;
      st_r.button_drive   <= 1'b0;
    end else if (step_go) begin
      st_r <= st_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step_go) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_mode_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(st_r.mode) && (st_r.mode != ST_BOARD_OFF))
    else $error("sequencer mode register corrupt or left in board off");

  a_off_no_atx: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_data_r.system_state == SYS_OFF) |-> !out_data_r.atx_enable)
    else $error("atx enabled while reporting off");

  a_on_led_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_data_r.system_state == SYS_ON) |-> (out_data_r.led_mode == LED_FULL))
    else $error("led mode not full while on");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step_go |=> $stable(st_r))
    else $error("state changed without a step");
`endif

endmodule

FILE: tb/sv/power_on_sequencer_checker.sv
`timescale 1ns / 1ps

module power_on_sequencer_checker
  import pos_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  item_t                in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  result_t              out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0]     cfg_data,
  output int                   mismatches,
  output int                   backlog
);

  logic [CNT_W-1:0] warm_limit;
  logic [CNT_W-1:0] pulse_limit;
  logic [CNT_W-1:0] hard_off_limit;

  mode_t            seq_mode;
  logic             button_through;
  logic             press_done;
  logic             button_was_down;
  logic [CNT_W-1:0] hold_count;
  logic             warming;
  logic [CNT_W-1:0] warm_count;
  logic             pulsing;
  logic [CNT_W-1:0] pulse_count;
  logic             atx_on;
  logic             board_btn;

  result_t expected_status[$];
  int      fail_total = 0;

  assign mismatches = fail_total;

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
    if (v == {CNT_W{1'b1}}) return v;
    return v + 1'b1;
  endfunction

  function automatic logic powered_board(input mode_t m);
    return (m == ST_BOARD_ON) || (m == ST_ON) || (m == ST_SLEEPING) || (m == ST_SHUTTING_DN);
  endfunction

  function automatic void set_mode(input mode_t m);
    if (seq_mode != m) begin
      seq_mode = m;
      button_through = !((m == ST_OFF) || (m == ST_BOOTING) || (m == ST_BOARD_OFF));
    end
  endfunction

  function automatic void enable_supply();
    atx_on = 1'b1;
    warming = 1'b1;
    warm_count = '0;
    set_mode(ST_BOOTING);
  endfunction

  function automatic result_t sequence_step(input item_t it);
    result_t    r;
    logic [1:0] led;
    if (it.tick_elapsed) begin
      if (warming) warm_count = bump(warm_count);
      if (pulsing) pulse_count = bump(pulse_count);
      if (button_was_down) hold_count = bump(hold_count);
    end
    if (it.wake_event && seq_mode == ST_OFF) enable_supply();
    if (pulsing && pulse_count >= pulse_limit) begin
      board_btn = 1'b0;
      pulsing = 1'b0;
    end
    if (warming && warm_count >= warm_limit) begin
      pulsing = 1'b1;
      pulse_count = '0;
      board_btn = 1'b1;
      warming = 1'b0;
    end
    if (!it.rail_powered && powered_board(seq_mode)) set_mode(ST_BOARD_OFF);
    if (it.rail_powered && seq_mode == ST_BOOTING) set_mode(ST_BOARD_ON);

    if (it.button_pressed != button_was_down) begin
      if (it.button_pressed) hold_count = '0;
      press_done = 1'b0;
    end
    button_was_down = it.button_pressed;
    if (it.button_pressed && hold_count >= hard_off_limit) begin
      press_done = 1'b1;
      board_btn = 1'b0;
      pulsing = 1'b0;
      warming = 1'b0;
      atx_on = 1'b0;
      set_mode(ST_OFF);
    end else if (!press_done) begin
      if (!button_through) begin
        if (seq_mode == ST_OFF && it.button_pressed) begin
          enable_supply();
          press_done = 1'b1;
        end
      end else if (!pulsing) begin
        board_btn = it.button_pressed;
      end
    end

    if (it.command_valid && powered_board(seq_mode)) begin
      case (it.command_byte)
        CMD_ON: set_mode(ST_ON);
        CMD_SHUTDOWN: set_mode(ST_SHUTTING_DN);
        CMD_SLEEP: set_mode(ST_SLEEPING);
        default: ;
      endcase
    end

    if (seq_mode == ST_OFF) led = LED_DARK;
    else if (seq_mode == ST_ON) led = LED_FULL;
    else led = LED_PULSE;

    if (seq_mode == ST_BOARD_OFF) begin
      atx_on = 1'b0;
      set_mode(ST_OFF);
    end

    r.atx_enable = atx_on;
    r.board_button = board_btn;
    r.led_mode = led;
    case (seq_mode)
      ST_BOOTING: r.system_state = SYS_BOOTING;
      ST_BOARD_ON: r.system_state = SYS_BOARD_ON;
      ST_ON: r.system_state = SYS_ON;
      ST_SLEEPING: r.system_state = SYS_SLEEPING;
      ST_SHUTTING_DN: r.system_state = SYS_SHUTTING_DN;
      default: r.system_state = SYS_OFF;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      warm_limit = WARMUP_RST;
      pulse_limit = PULSE_RST;
      hard_off_limit = LONG_PRESS_RST;
      seq_mode = ST_OFF;
      button_through = 1'b0;
      press_done = 1'b0;
      button_was_down = 1'b0;
      hold_count = '0;
      warming = 1'b0;
      warm_count = '0;
      pulsing = 1'b0;
      pulse_count = '0;
      atx_on = 1'b0;
      board_btn = 1'b0;
      expected_status.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WARMUP: warm_limit = cfg_data;
          CFG_PULSE: pulse_limit = cfg_data;
          CFG_LONG_PRESS: hard_off_limit = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_status.size() == 0) begin
          if (fail_total < 10)
            $display("unexpected result atx=%0d btn=%0d state=%0d led=%0d at %0t",
                     out_data.atx_enable, out_data.board_button, out_data.system_state,
                     out_data.led_mode, $realtime);
          fail_total++;
        end else begin
          want = expected_status.pop_front();
          if (out_data.atx_enable !== want.atx_enable ||
              out_data.board_button !== want.board_button ||
              out_data.system_state !== want.system_state ||
              out_data.led_mode !== want.led_mode) begin
            if (fail_total < 10)
              $display("mismatch at %0t: expected atx=%0d btn=%0d state=%0d led=%0d, got atx=%0d btn=%0d state=%0d led=%0d",
                       $realtime, want.atx_enable, want.board_button, want.system_state,
                       want.led_mode, out_data.atx_enable, out_data.board_button,
                       out_data.system_state, out_data.led_mode);
            fail_total++;
          end
        end
      end
      if (in_valid && in_ready) expected_status.push_back(sequence_step(in_data));
    end
    backlog = expected_status.size();
  end

endmodule

FILE: tb/sv/power_on_sequencer_tb.sv
`timescale 1ns / 1ps

module power_on_sequencer_tb;
  import pos_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int HOLD_CYCLES = 48;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  item_t                in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  result_t              out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CNT_W-1:0]     cfg_data = '0;

  int   mismatches;
  int   backlog;
  logic sender_idles = 1'b1;
  logic stall_bursts = 1'b1;
  int   holds_requested = 0;
  logic rail_level = 1'b0;
  logic button_level = 1'b0;

  always #4 clk = ~clk;

  power_on_sequencer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  power_on_sequencer_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .backlog(backlog)
  );

  // result side: random stall bursts plus the long hold-off on request
  initial begin
    int holds_served;
    holds_served = 0;
    forever begin
      if (holds_requested != holds_served) begin
        holds_served++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (stall_bursts && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic item_t compose(input int tick, input int btn, input int rail,
                                    input int wake, input int cmd_v,
                                    input logic [7:0] cmd);
    item_t it;
    it.tick_elapsed = tick[0];
    it.button_pressed = btn[0];
    it.rail_powered = rail[0];
    it.wake_event = wake[0];
    it.command_valid = cmd_v[0];
    it.command_byte = cmd;
    return it;
  endfunction

  // mostly plausible level sequences, some pure noise
  function automatic item_t random_item();
    item_t       it;
    logic [31:0] raw;
    raw = $urandom;
    if ($urandom_range(0, 9) == 0) begin
      it = raw[$bits(item_t)-1:0];
      return it;
    end
    if ($urandom_range(0, 29) == 0) rail_level = ~rail_level;
    if ($urandom_range(0, 11) == 0) button_level = ~button_level;
    it.tick_elapsed = ($urandom_range(0, 3) != 0);
    it.button_pressed = button_level;
    it.rail_powered = rail_level;
    it.wake_event = ($urandom_range(0, 19) == 0);
    it.command_valid = ($urandom_range(0, 4) == 0);
    case ($urandom_range(0, 4))
      0: it.command_byte = CMD_ON;
      1: it.command_byte = CMD_SLEEP;
      2: it.command_byte = CMD_SHUTDOWN;
      default: it.command_byte = raw[15:8];
    endcase
    return it;
  endfunction

  task automatic send_item(input item_t it);
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (backlog != 0);
  endtask

  task automatic write_regs(input logic [31:0] warm, input logic [31:0] pulse,
                            input logic [31:0] hard_off);
    logic [CFG_IDX_W-1:0] idx[4];
    logic [31:0]          val[4];
    idx[0] = CFG_WARMUP;
    val[0] = warm;
    idx[1] = CFG_PULSE;
    val[1] = pulse;
    idx[2] = CFG_LONG_PRESS;
    val[2] = hard_off;
    idx[3] = CFG_SPARE;
    val[3] = $urandom;
    for (int k = 0; k < 4; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data <= val[k][CNT_W-1:0];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int          phase_len[6];
    logic [31:0] phase_cfg[6][3];
    phase_len = '{150, 150, 120, 60, 150, 250};
    phase_cfg[0] = '{4, 3, 20};
    phase_cfg[2] = '{0, 0, 0};
    phase_cfg[3] = '{65535, 65535, 65535};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values
    send_item(compose(0, 0, 0, 0, 0, 8'h00));
    send_item(compose(1, 0, 0, 1, 0, 8'h00));
    send_item(compose(0, 0, 0, 0, 1, CMD_ON));
    send_item(compose(1, 0, 1, 0, 0, 8'h00));
    send_item(compose(0, 0, 1, 0, 1, 8'h55));
    send_item(compose(0, 0, 0, 0, 0, 8'h00));
    settle();

    write_regs(1, 2, 3);
    send_item(compose(0, 1, 0, 0, 0, 8'h00));
    send_item(compose(1, 1, 0, 0, 0, 8'h00));
    send_item(compose(1, 0, 1, 0, 0, 8'h00));
    send_item(compose(1, 0, 1, 0, 0, 8'h00));
    send_item(compose(0, 0, 1, 0, 1, CMD_ON));
    send_item(compose(0, 1, 1, 0, 0, 8'h00));
    send_item(compose(0, 0, 1, 0, 0, 8'h00));
    send_item(compose(0, 0, 1, 0, 1, CMD_SLEEP));
    send_item(compose(0, 0, 1, 0, 1, CMD_SHUTDOWN));
    repeat (5) send_item(compose(1, 1, 1, 0, 0, 8'h00));
    send_item(compose(0, 0, 0, 1, 1, CMD_SHUTDOWN));
    send_item(compose(1, 1, 1, 1, 1, 8'hFF));
    send_item(compose(1, 0, 0, 0, 0, 8'h00));
    settle();

    // zero long press: any press is a hard off
    write_regs(0, 0, 0);
    send_item(compose(0, 1, 1, 1, 0, 8'h00));
    send_item(compose(1, 1, 1, 0, 0, 8'h00));
    settle();

    for (int p = 0; p < 6; p++) begin
      if (p == 1 || p >= 4)
        write_regs($urandom_range(0, 12), $urandom_range(0, 12), $urandom_range(0, 30));
      else
        write_regs(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2]);
      if (p == 0) holds_requested++;
      if (p == 5) begin
        sender_idles <= 1'b0;
        stall_bursts <= 1'b0;
      end
      for (int n = 0; n < phase_len[p]; n++) send_item(random_item());
      settle();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && backlog == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
